>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

>>> hw/rtl/bplru_pkg.sv
package bplru_pkg;

	localparam int POOL_SIZE_DEF = 16;

	localparam logic [1:0] CMD_FIX    = 2'd0;
	localparam logic [1:0] CMD_UNFIX  = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] ST_HIT          = 3'd0;
	localparam logic [2:0] ST_LOAD_EMPTY   = 3'd1;
	localparam logic [2:0] ST_LOAD_EVICT   = 3'd2;
	localparam logic [2:0] ST_ALL_PINNED   = 3'd3;
	localparam logic [2:0] ST_UNFIXED      = 3'd4;
	localparam logic [2:0] ST_NOT_RESIDENT = 3'd5;
	localparam logic [2:0] ST_FLUSH_WRITE  = 3'd6;
	localparam logic [2:0] ST_FLUSH_NONE   = 3'd7;

	localparam logic [7:0] PIN_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] page_id;
		logic        mark_dirty;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  frame_index;
		logic        fetch_page;
		logic        writeback;
		logic [31:0] writeback_page;
		logic        last;
	} rsp_t;

	// One frame as it is kept in the frame memory.
	typedef struct packed {
		logic [31:0] tag;
		logic [7:0]  pin;
		logic        dirty;
		logic [31:0] stamp;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic scan;
		logic act;
		logic fchk;
		logic fend;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_last;
		logic res_busy;
		logic fl_stall;
	} sts_t;

endpackage

>>> hw/rtl/bplru_ram.sv
module bplru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/bplru_dp.sv
module bplru_dp import bplru_pkg::*; #(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  ctl_t ctl,
	output sts_t sts,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_SIZE - 1);

	logic [1:0]           cmd_q;
	logic [31:0]          page_q;
	logic                 mark_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     rdidx_s1;
	logic                 rdv_s1;
	logic [POOL_SIZE-1:0] valid_q;
	logic [31:0]          clock_q;
	logic                 hit_q, emp_q, vic_q;
	logic [IDX_W-1:0]     hit_idx_q, emp_idx_q, vic_idx_q;
	entry_t               hit_ent_q, vic_ent_q;
	logic                 pend_q;
	logic [IDX_W-1:0]     pend_idx_q;
	logic [31:0]          pend_tag_q;
	rsp_t                 res_q;
	logic                 res_valid_q;

	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata, rdata;

	bplru_ram #(.WIDTH($bits(entry_t)), .DEPTH(POOL_SIZE)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// Per-entry checks for the lookup scan and the flush walk.
	logic v_rd, s_match, s_empty, s_older, f_qual, f_stall, f_go;
	assign v_rd    = valid_q[rdidx_s1];
	assign s_match = rdv_s1 && v_rd && (rdata.tag == page_q) && !hit_q;
	assign s_empty = rdv_s1 && !v_rd && !emp_q;
	assign s_older = rdv_s1 && v_rd && (rdata.pin == 8'd0)
		&& (!vic_q || (rdata.stamp < vic_ent_q.stamp));
	assign f_qual  = valid_q[idx_q] && rdata.dirty && (rdata.pin == 8'd0);
	assign f_stall = f_qual && pend_q && res_valid_q;
	assign f_go    = ctl.fchk && !f_stall;

	assign sts.idx_last = (idx_q == IDX_LAST);
	assign sts.res_busy = res_valid_q;
	assign sts.fl_stall = f_stall;

	// Decision after the scan, the flush clear of the dirty bit, and the memory writes they cause.
	entry_t           ent;
	rsp_t             act_res;
	logic             act_bump, act_set;
	logic [IDX_W-1:0] act_slot;
	always_comb begin
		we       = 1'b0;
		waddr    = idx_q;
		wdata    = rdata;
		ent      = hit_ent_q;
		act_res  = '0;
		act_res.last = 1'b1;
		act_bump = 1'b0;
		act_set  = 1'b0;
		act_slot = emp_q ? emp_idx_q : vic_idx_q;
		if (ctl.fchk && f_qual && !f_stall) begin
			we          = 1'b1;
			wdata.dirty = 1'b0;
		end
		if (ctl.act) begin
			unique case (cmd_q)
				CMD_FIX: begin
					if (hit_q) begin
						if (ent.pin != PIN_MAX) begin
							ent.pin = ent.pin + 8'd1;
						end
						ent.dirty = ent.dirty | mark_q;
						ent.stamp = clock_q;
						we = 1'b1;
						waddr = hit_idx_q;
						wdata = ent;
						act_bump = 1'b1;
						act_res.status = ST_HIT;
						act_res.frame_index = 6'(hit_idx_q);
					end else if (emp_q || vic_q) begin
						ent.tag = page_q;
						ent.pin = 8'd1;
						ent.dirty = mark_q;
						ent.stamp = clock_q;
						we = 1'b1;
						waddr = act_slot;
						wdata = ent;
						act_bump = 1'b1;
						act_set = 1'b1;
						act_res.status = emp_q ? ST_LOAD_EMPTY : ST_LOAD_EVICT;
						act_res.frame_index = 6'(act_slot);
						act_res.fetch_page = 1'b1;
						if (!emp_q && vic_ent_q.dirty) begin
							act_res.writeback = 1'b1;
							act_res.writeback_page = vic_ent_q.tag;
						end
					end else begin
						act_res.status = ST_ALL_PINNED;
					end
				end
				CMD_UNFIX: begin
					if (hit_q) begin
						if (ent.pin != 8'd0) begin
							ent.pin = ent.pin - 8'd1;
						end
						ent.dirty = ent.dirty | mark_q;
						ent.stamp = clock_q;
						we = 1'b1;
						waddr = hit_idx_q;
						wdata = ent;
						act_bump = 1'b1;
						act_res.status = ST_UNFIXED;
						act_res.frame_index = 6'(hit_idx_q);
					end else begin
						act_res.status = ST_NOT_RESIDENT;
					end
				end
				default: begin
					act_res.status = ST_FLUSH_NONE;
				end
			endcase
		end
	end

	// Flush result: the pending write, or the empty flush marker.
	rsp_t fl_res;
	always_comb begin
		fl_res = '0;
		if (pend_q) begin
			fl_res.status         = ST_FLUSH_WRITE;
			fl_res.frame_index    = 6'(pend_idx_q);
			fl_res.writeback      = 1'b1;
			fl_res.writeback_page = pend_tag_q;
			fl_res.last           = ctl.fend;
		end else begin
			fl_res.status = ST_FLUSH_NONE;
			fl_res.last   = 1'b1;
		end
	end

	// Control state of the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			clock_q     <= '0;
			rdv_s1      <= 1'b0;
			hit_q       <= 1'b0;
			emp_q       <= 1'b0;
			vic_q       <= 1'b0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			rdv_s1 <= ctl.scan;
			if (ctl.start) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				emp_q  <= 1'b0;
				vic_q  <= 1'b0;
				pend_q <= 1'b0;
			end else if (ctl.scan || f_go) begin
				idx_q <= idx_q + 1'b1;
			end
			if (s_match) hit_q <= 1'b1;
			if (s_empty) emp_q <= 1'b1;
			if (s_older) vic_q <= 1'b1;
			if (f_go && f_qual) pend_q <= 1'b1;
			if (ctl.fend) pend_q <= 1'b0;
			if (act_set) valid_q[act_slot] <= 1'b1;
			if (act_bump) clock_q <= clock_q + 32'd1;
			if (rsp_valid && rsp_ready) begin
				res_valid_q <= 1'b0;
			end
			if (ctl.act || ctl.fend || (f_go && f_qual && pend_q)) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers: request, scan and flush captures and the result.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cmd_q  <= req.command;
			page_q <= req.page_id;
			mark_q <= req.mark_dirty;
		end
		rdidx_s1 <= idx_q;
		if (s_match) begin
			hit_idx_q <= rdidx_s1;
			hit_ent_q <= rdata;
		end
		if (s_empty) emp_idx_q <= rdidx_s1;
		if (s_older) begin
			vic_idx_q <= rdidx_s1;
			vic_ent_q <= rdata;
		end
		if (f_go && f_qual) begin
			pend_idx_q <= idx_q;
			pend_tag_q <= rdata.tag;
		end
		if (ctl.act) begin
			res_q <= act_res;
		end else if (ctl.fend || (f_go && f_qual && pend_q)) begin
			res_q <= fl_res;
		end
	end

	assign rsp_valid = res_valid_q;
	assign rsp       = res_q;

endmodule

>>> hw/rtl/bplru_ctrl.sv
module bplru_ctrl import bplru_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [1:0] command,
	input  sts_t       sts,
	output ctl_t       ctl
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_TAIL = 3'd2;
	localparam logic [2:0] S_ACT  = 3'd3;
	localparam logic [2:0] S_FRD  = 3'd4;
	localparam logic [2:0] S_FCHK = 3'd5;
	localparam logic [2:0] S_FEND = 3'd6;

	logic [2:0] state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		ctl.start = req_valid && req_ready;
		ctl.scan  = (state_q == S_SCAN);
		ctl.act   = (state_q == S_ACT) && !sts.res_busy;
		ctl.fchk  = (state_q == S_FCHK);
		ctl.fend  = (state_q == S_FEND) && !sts.res_busy;
		unique case (state_q)
			S_IDLE: begin
				if (ctl.start) begin
					state_d = (command == CMD_FLUSH) ? S_FRD : S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.idx_last) state_d = S_TAIL;
			end
			S_TAIL: state_d = S_ACT;
			S_ACT: begin
				if (!sts.res_busy) state_d = S_IDLE;
			end
			S_FRD: state_d = S_FCHK;
			S_FCHK: begin
				if (!sts.fl_stall) state_d = sts.idx_last ? S_FEND : S_FRD;
			end
			S_FEND: begin
				if (!sts.res_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/buffer_pool_lru_frame_manager_unit.sv
// Buffer pool frame manager with least-recently-used replacement. A fix or
// unfix walks the frame memory one frame a cycle through its registered read
// port, so its result is registered after the walk, once any previous result
// has been taken on rsp_ready, and the next request can be taken in the cycle
// after that. A flush reads each frame and then checks it and clears its
// dirty bit, stalling at the check while the previous result is not taken,
// and closes with a final step; it holds each write result back one step so
// that the final one carries last.
// A new request is taken once the previous one has finished its walk.
`include "assert_macros.svh"

module buffer_pool_lru_frame_manager_unit import bplru_pkg::*; #(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ctl_t ctl;
	sts_t sts;

	bplru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.command   (req.command),
		.sts       (sts),
		.ctl       (ctl)
	);

	bplru_dp #(.POOL_SIZE(POOL_SIZE)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// A request transaction is followed by a busy cycle.
	`ASSERT_CLK(a_busy_after_req, clk, arst_n, (req_valid && req_ready) |=> !req_ready)
	// Flush write results always ask for a writeback.
	`ASSERT_CLK(a_flush_wb, clk, arst_n,
		(rsp_valid && rsp.status == ST_FLUSH_WRITE) |-> rsp.writeback)
	// Only loads fetch a page.
	`ASSERT_NEVER(a_fetch_load, clk, arst_n, rsp_valid && rsp.fetch_page &&
		rsp.status != ST_LOAD_EMPTY && rsp.status != ST_LOAD_EVICT)

endmodule

>>> bench/buffer_pool_lru_frame_manager_unit_checker.sv
`timescale 1ns / 100ps

module buffer_pool_lru_frame_manager_unit_checker import bplru_pkg::*; #(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   error_count,
	output int   pending_count
);

	// Shadow copy of the frame table.
	logic [31:0] shadow_tag [POOL_SIZE];
	logic        shadow_valid [POOL_SIZE];
	logic [7:0]  shadow_pin [POOL_SIZE];
	logic        shadow_dirty [POOL_SIZE];
	logic [31:0] shadow_stamp [POOL_SIZE];
	logic [31:0] shadow_clock;

	rsp_t expected_rsp_q[$];

	assign pending_count = expected_rsp_q.size();

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic rsp_t make_rsp(input logic [2:0] status, input int frame,
		input logic fetch, input logic wb, input logic [31:0] wb_page, input logic last);
		rsp_t r;
		r.status = status;
		r.frame_index = 6'(frame);
		r.fetch_page = fetch;
		r.writeback = wb;
		r.writeback_page = wb_page;
		r.last = last;
		return r;
	endfunction

	function automatic int find_frame(input logic [31:0] page);
		for (int i = 0; i < POOL_SIZE; i++)
			if (shadow_valid[i] && shadow_tag[i] == page)
				return i;
		return -1;
	endfunction

	// Work out the results of one request and update the shadow table.
	task automatic predict_frame_results(input req_t r);
		int hit;
		int slot;
		int n;
		logic [2:0] status;
		logic wb;
		logic [31:0] wb_page;
		hit = find_frame(r.page_id);
		slot = -1;
		n = 0;
		wb = 1'b0;
		wb_page = '0;
		case (r.command)
			CMD_FIX: begin
				if (hit >= 0) begin
					if (shadow_pin[hit] != PIN_MAX)
						shadow_pin[hit]++;
					if (r.mark_dirty)
						shadow_dirty[hit] = 1'b1;
					shadow_stamp[hit] = shadow_clock++;
					expected_rsp_q.push_back(make_rsp(ST_HIT, hit, 0, 0, 0, 1));
				end else begin
					for (int i = 0; i < POOL_SIZE && slot < 0; i++)
						if (!shadow_valid[i])
							slot = i;
					status = ST_LOAD_EMPTY;
					if (slot < 0) begin
						for (int i = 0; i < POOL_SIZE; i++)
							if (shadow_pin[i] == 0 &&
								(slot < 0 || shadow_stamp[i] < shadow_stamp[slot]))
								slot = i;
						status = ST_LOAD_EVICT;
						if (slot >= 0 && shadow_dirty[slot]) begin
							wb = 1'b1;
							wb_page = shadow_tag[slot];
						end
					end
					if (slot < 0) begin
						expected_rsp_q.push_back(make_rsp(ST_ALL_PINNED, 0, 0, 0, 0, 1));
					end else begin
						shadow_valid[slot] = 1'b1;
						shadow_tag[slot] = r.page_id;
						shadow_pin[slot] = 8'd1;
						shadow_dirty[slot] = r.mark_dirty;
						shadow_stamp[slot] = shadow_clock++;
						expected_rsp_q.push_back(make_rsp(status, slot, 1, wb, wb_page, 1));
					end
				end
			end
			CMD_UNFIX: begin
				if (hit < 0) begin
					expected_rsp_q.push_back(make_rsp(ST_NOT_RESIDENT, 0, 0, 0, 0, 1));
				end else begin
					if (shadow_pin[hit] != 0)
						shadow_pin[hit]--;
					if (r.mark_dirty)
						shadow_dirty[hit] = 1'b1;
					shadow_stamp[hit] = shadow_clock++;
					expected_rsp_q.push_back(make_rsp(ST_UNFIXED, hit, 0, 0, 0, 1));
				end
			end
			CMD_FLUSH: begin
				for (int i = 0; i < POOL_SIZE; i++) begin
					if (shadow_valid[i] && shadow_dirty[i] && shadow_pin[i] == 0) begin
						expected_rsp_q.push_back(make_rsp(ST_FLUSH_WRITE, i, 0, 1,
							shadow_tag[i], 0));
						shadow_dirty[i] = 1'b0;
						n++;
					end
				end
				if (n == 0)
					expected_rsp_q.push_back(make_rsp(ST_FLUSH_NONE, 0, 0, 0, 0, 1));
				else
					expected_rsp_q[$].last = 1'b1;
			end
			default: begin
				expected_rsp_q.push_back(make_rsp(ST_FLUSH_NONE, 0, 0, 0, 0, 1));
			end
		endcase
	endtask

	// Predict on every request transaction and check every response transaction.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				shadow_tag[i] = '0;
				shadow_valid[i] = 1'b0;
				shadow_pin[i] = '0;
				shadow_dirty[i] = 1'b0;
				shadow_stamp[i] = '0;
			end
			shadow_clock = '0;
			error_count = 0;
			expected_rsp_q.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("unexpected response", 32'(rsp), 0);
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.frame_index !== want.frame_index)
						report_mismatch("frame_index", 32'(rsp.frame_index),
							32'(want.frame_index));
					if (rsp.fetch_page !== want.fetch_page)
						report_mismatch("fetch_page", 32'(rsp.fetch_page),
							32'(want.fetch_page));
					if (rsp.writeback !== want.writeback)
						report_mismatch("writeback", 32'(rsp.writeback),
							32'(want.writeback));
					if (rsp.writeback_page !== want.writeback_page)
						report_mismatch("writeback_page", rsp.writeback_page,
							want.writeback_page);
					if (rsp.last !== want.last)
						report_mismatch("last", 32'(rsp.last), 32'(want.last));
				end
			end
			if (req_valid && req_ready)
				predict_frame_results(req);
		end
	end

endmodule

>>> bench/buffer_pool_lru_frame_manager_unit_tb.sv
`timescale 1ns / 100ps

module buffer_pool_lru_frame_manager_unit_tb import bplru_pkg::*;;

	localparam int POOL = POOL_SIZE_DEF;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;
	int   error_count;
	int   pending_count;
	logic calm;

	// Small working set of pages so that hits and evictions are common.
	logic [31:0] page_set [24];

	buffer_pool_lru_frame_manager_unit #(.POOL_SIZE(POOL)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	buffer_pool_lru_frame_manager_unit_checker #(.POOL_SIZE(POOL)) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.error_count(error_count),
		.pending_count(pending_count)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// The response side stalls now and then, except during the calm stretch.
	always @(negedge clk) begin
		rsp_ready <= calm || ($urandom_range(99) >= 6);
	end

	// Send one request transaction, with an occasional idle gap first.
	task automatic send_frame_request(input logic [1:0] command, input logic [31:0] page,
		input logic dirty);
		while (!calm && $urandom_range(99) < 6) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= '{command, page, dirty};
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int sel;
		logic [1:0] cmd;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		for (int i = 0; i < 24; i++)
			page_set[i] = (i < 2) ? (i == 0 ? 32'h0 : 32'hFFFF_FFFF) : $urandom();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: empty flush, misses, extremes, pool filled and all pinned.
		send_frame_request(CMD_FLUSH, 32'h0, 1'b0);
		send_frame_request(CMD_UNFIX, 32'hFFFF_FFFF, 1'b1);
		send_frame_request(CMD_FIX, 32'h0, 1'b1);
		send_frame_request(CMD_FIX, 32'hFFFF_FFFF, 1'b0);
		send_frame_request(CMD_FIX, 32'h0, 1'b0);
		send_frame_request(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1);
		for (int i = 2; i < POOL; i++)
			send_frame_request(CMD_FIX, 32'hA5A5_0000 + i, i[0]);
		send_frame_request(CMD_FIX, 32'h1234_5678, 1'b1);
		send_frame_request(CMD_UNFIX, 32'h0, 1'b0);
		send_frame_request(CMD_UNFIX, 32'h0, 1'b0);
		send_frame_request(CMD_UNFIX, 32'h0, 1'b0);
		send_frame_request(CMD_FLUSH, 32'h5555_5555, 1'b1);
		send_frame_request(CMD_FIX, 32'h1234_5678, 1'b0);

		// Random part, mostly over the working set, with a calm stretch in the middle.
		for (int n = 0; n < 232; n++) begin
			calm = (n >= 90 && n < 150);
			sel = $urandom_range(99);
			cmd = (sel < 45) ? CMD_FIX : (sel < 88) ? CMD_UNFIX :
				(sel < 97) ? CMD_FLUSH : CMD_UNUSED;
			if ($urandom_range(9) == 0)
				send_frame_request(cmd, $urandom(), 1'($urandom_range(1)));
			else
				send_frame_request(cmd, page_set[$urandom_range(23)],
					1'($urandom_range(1)));
		end
		calm = 1'b0;

		// Release a frame and write back every dirty unpinned frame.
		send_frame_request(CMD_UNFIX, 32'hFFFF_FFFF, 1'b1);
		send_frame_request(CMD_FLUSH, 32'h0, 1'b0);
		req_valid <= 1'b0;

		while (pending_count != 0)
			@(posedge clk);
		repeat (2 * POOL + 8) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
